[design/skvr_pkg.sv]
package skvr_pkg;

   localparam int DEPTH       = 256;
   localparam int INDEX_W     = 8;
   localparam int COUNT_W     = 9;
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_COUNT = DEPTH / GROUP_SIZE;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
   localparam logic [OP_W-1:0] OP_MERGE  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

   // Broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic                      compare_en;
      logic                      read_mode;
      logic                      place_en;
      logic                      replace_en;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
      logic [COUNT_W-1:0]        count;
   } cell_cmd_type;

endpackage

[design/skvr_cell.sv]
module skvr_cell (
   input  logic                                clock,
   input  skvr_pkg::cell_cmd_type              cmd,
   input  logic [skvr_pkg::INDEX_W-1:0]        pos,
   input  logic signed [skvr_pkg::KEY_W-1:0]   left_key,
   input  logic signed [skvr_pkg::VALUE_W-1:0] left_value,
   input  logic                                left_lt,
   output logic signed [skvr_pkg::KEY_W-1:0]   key,
   output logic signed [skvr_pkg::VALUE_W-1:0] value,
   output logic                                lt,
   output logic                                sel,
   output logic [skvr_pkg::KEY_W-1:0]          sel_key,
   output logic [skvr_pkg::VALUE_W-1:0]        sel_value
);

   logic signed [skvr_pkg::KEY_W-1:0]   key_ff;
   logic signed [skvr_pkg::VALUE_W-1:0] value_ff;
   logic                                lt_ff;
   logic                                sel_ff;
   logic                                valid;
   logic                                lt_in;
   logic                                sel_in;

   always_comb begin
      valid  = {1'b0, pos} < cmd.count;
      lt_in  = valid && (key_ff < cmd.key);
      if (cmd.read_mode) begin
         sel_in = valid && (pos == cmd.index);
      end else begin
         sel_in = valid && (key_ff == cmd.key);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare_en) begin
         lt_ff  <= lt_in;
         sel_ff <= sel_in;
      end
   end

   // An insertion opens a gap at the first cell whose key is not smaller;
   // the cells above it take their left neighbor's pair in the same cycle.
   always_ff @(posedge clock) begin
      if (cmd.place_en) begin
         if (!lt_ff) begin
            if (left_lt) begin
               key_ff   <= cmd.key;
               value_ff <= cmd.value;
            end else begin
               key_ff   <= left_key;
               value_ff <= left_value;
            end
         end
      end else if (cmd.replace_en && sel_ff) begin
         value_ff <= cmd.value;
      end
   end

   assign key       = key_ff;
   assign value     = value_ff;
   assign lt        = lt_ff;
   assign sel       = sel_ff;
   assign sel_key   = sel_ff ? key_ff : '0;
   assign sel_value = sel_ff ? value_ff : '0;

endmodule

[design/skvr_reduce.sv]
module skvr_reduce (
   input  logic                         clock,
   input  logic [skvr_pkg::DEPTH-1:0]   sel,
   input  logic [skvr_pkg::KEY_W-1:0]   sel_key   [skvr_pkg::DEPTH],
   input  logic [skvr_pkg::VALUE_W-1:0] sel_value [skvr_pkg::DEPTH],
   output logic                         hit,
   output logic [skvr_pkg::KEY_W-1:0]   hit_key,
   output logic [skvr_pkg::VALUE_W-1:0] hit_value
);

   // At most one cell is selected, so an OR gathers its pair.
   logic [skvr_pkg::GROUP_COUNT-1:0] grp_hit_ff;
   logic [skvr_pkg::KEY_W-1:0]       grp_key_ff   [skvr_pkg::GROUP_COUNT];
   logic [skvr_pkg::VALUE_W-1:0]     grp_value_ff [skvr_pkg::GROUP_COUNT];
   logic                             hit_ff;
   logic [skvr_pkg::KEY_W-1:0]       key_ff;
   logic [skvr_pkg::VALUE_W-1:0]     value_ff;
   logic [skvr_pkg::KEY_W-1:0]       key_in;
   logic [skvr_pkg::VALUE_W-1:0]     value_in;

   for (genvar g = 0; g < skvr_pkg::GROUP_COUNT; g++) begin : g_group
      logic [skvr_pkg::KEY_W-1:0]   gk;
      logic [skvr_pkg::VALUE_W-1:0] gv;
      always_comb begin
         gk = '0;
         gv = '0;
         for (int j = 0; j < skvr_pkg::GROUP_SIZE; j++) begin
            gk = gk | sel_key[g*skvr_pkg::GROUP_SIZE + j];
            gv = gv | sel_value[g*skvr_pkg::GROUP_SIZE + j];
         end
      end
      always_ff @(posedge clock) begin
         grp_hit_ff[g]   <= |sel[g*skvr_pkg::GROUP_SIZE +: skvr_pkg::GROUP_SIZE];
         grp_key_ff[g]   <= gk;
         grp_value_ff[g] <= gv;
      end
   end

   always_comb begin
      key_in   = '0;
      value_in = '0;
      for (int g = 0; g < skvr_pkg::GROUP_COUNT; g++) begin
         key_in   = key_in | grp_key_ff[g];
         value_in = value_in | grp_value_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= |grp_hit_ff;
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign hit       = hit_ff;
   assign hit_key   = key_ff;
   assign hit_value = value_ff;

endmodule

[design/sorted_key_value_run.sv]
// Sorted key/value run: up to 256 pairs kept in ascending signed key order.
// Requests arrive on req_ (tvalid/tready/tdata); each one yields exactly one
// response on rsp_. The capacity register is written through csr_, which is
// always ready; write it only while no request is in flight.
// The store is a row of 256 cells. Each cell compares its own key with the
// broadcast key, and on an insertion every cell above the insertion point
// takes its left neighbor's pair, so the whole row shifts at once.
// A request passes from acceptance to a loaded response through the compare
// in all cells, the registered 16-by-16 tree that gathers the hit flag and
// the selected pair, and the update of the row and the response register.
// The next request is taken in the cycle after the row has been updated, so
// requests are handled one at a time, paced by the compare and gather path
// through the cell row.
// The response sits in an output register; a new request is accepted while
// it waits. If the receiver stalls so long that the next response is ready
// before the old one is taken, the row update waits with it.
// Reset empties the run and sets the capacity to 256. Cell contents are not
// cleared; entries at or above the count are never read.
module sorted_key_value_run (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // op[2:0], key[34:3], value[66:35], index[74:67], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // found[0], key_out[32:1], value_out[64:33],
                                    // status[66:65], count[75:67], zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data     // capacity
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_COMPARE = 5'b00010,
      ST_TREE1   = 5'b00100,
      ST_TREE2   = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [skvr_pkg::OP_W-1:0]           op_ff;
   logic signed [skvr_pkg::KEY_W-1:0]   key_ff;
   logic signed [skvr_pkg::VALUE_W-1:0] value_ff;
   logic [skvr_pkg::INDEX_W-1:0]        index_ff;
   logic [skvr_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [skvr_pkg::COUNT_W-1:0]        capacity_ff;
   logic                                rsp_valid_ff;
   logic [79:0]                         rsp_data_ff, rsp_data_in;

   skvr_pkg::cell_cmd_type cmd;

   logic signed [skvr_pkg::KEY_W-1:0]   cell_key   [skvr_pkg::DEPTH];
   logic signed [skvr_pkg::VALUE_W-1:0] cell_value [skvr_pkg::DEPTH];
   logic [skvr_pkg::DEPTH-1:0]          cell_lt;
   logic [skvr_pkg::DEPTH-1:0]          cell_sel;
   logic [skvr_pkg::KEY_W-1:0]          cell_sel_key   [skvr_pkg::DEPTH];
   logic [skvr_pkg::VALUE_W-1:0]        cell_sel_value [skvr_pkg::DEPTH];

   logic                         hit;
   logic [skvr_pkg::KEY_W-1:0]   hit_key;
   logic [skvr_pkg::VALUE_W-1:0] hit_value;

   logic                            accept;
   logic                            commit;
   logic                            full;
   logic                            place_en;
   logic                            replace_en;
   logic                            found;
   logic [skvr_pkg::KEY_W-1:0]      key_out;
   logic [skvr_pkg::VALUE_W-1:0]    value_out;
   logic [skvr_pkg::STATUS_W-1:0]   status;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   // The row is updated only when the response register can take the result.
   assign commit     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_tdata[2:0];
         key_ff   <= req_tdata[34:3];
         value_ff <= req_tdata[66:35];
         index_ff <= req_tdata[74:67];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: state_in = ST_TREE1;
         ST_TREE1:   state_in = ST_TREE2;
         ST_TREE2:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Insert is refused at the logical capacity or when the row is full,
   // even for a key that is already present.
   always_comb begin
      full       = (count_ff >= capacity_ff) ||
                   (count_ff >= skvr_pkg::COUNT_W'(skvr_pkg::DEPTH));
      place_en   = 1'b0;
      replace_en = 1'b0;
      found      = 1'b0;
      key_out    = '0;
      value_out  = '0;
      status     = skvr_pkg::STATUS_OK;
      count_in   = count_ff;
      unique case (op_ff)
         skvr_pkg::OP_INSERT: begin
            if (full) begin
               status = skvr_pkg::STATUS_FULL;
            end else if (hit) begin
               replace_en = 1'b1;
            end else begin
               place_en = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         skvr_pkg::OP_LOOKUP: begin
            if (hit) begin
               found     = 1'b1;
               value_out = hit_value;
            end else begin
               status = skvr_pkg::STATUS_MISSING;
            end
         end
         skvr_pkg::OP_MERGE: begin
            if (hit) begin
               replace_en = 1'b1;
            end else if (count_ff < skvr_pkg::COUNT_W'(skvr_pkg::DEPTH)) begin
               place_en = 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               status = skvr_pkg::STATUS_OVERFLOW;
            end
         end
         skvr_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         skvr_pkg::OP_READ: begin
            if (hit) begin
               found     = 1'b1;
               key_out   = hit_key;
               value_out = hit_value;
            end else begin
               status = skvr_pkg::STATUS_MISSING;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in = {4'b0, count_in, status, value_out, key_out, found};
   end

   always_comb begin
      cmd.compare_en = (state_ff == ST_COMPARE);
      cmd.read_mode  = (op_ff == skvr_pkg::OP_READ);
      cmd.place_en   = commit && place_en;
      cmd.replace_en = commit && replace_en;
      cmd.key        = key_ff;
      cmd.value      = value_ff;
      cmd.index      = index_ff;
      cmd.count      = count_ff;
   end

   for (genvar i = 0; i < skvr_pkg::DEPTH; i++) begin : g_cell
      logic signed [skvr_pkg::KEY_W-1:0]   left_key;
      logic signed [skvr_pkg::VALUE_W-1:0] left_value;
      logic                                left_lt;
      if (i == 0) begin : g_first
         // Everything sits above the bottom edge of the row.
         assign left_key   = '0;
         assign left_value = '0;
         assign left_lt    = 1'b1;
      end else begin : g_rest
         assign left_key   = cell_key[i-1];
         assign left_value = cell_value[i-1];
         assign left_lt    = cell_lt[i-1];
      end
      skvr_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (skvr_pkg::INDEX_W'(i)),
         .left_key   (left_key),
         .left_value (left_value),
         .left_lt    (left_lt),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .lt         (cell_lt[i]),
         .sel        (cell_sel[i]),
         .sel_key    (cell_sel_key[i]),
         .sel_value  (cell_sel_value[i])
      );
   end

   skvr_reduce u_reduce (
      .clock     (clock),
      .sel       (cell_sel),
      .sel_key   (cell_sel_key),
      .sel_value (cell_sel_value),
      .hit       (hit),
      .hit_key   (hit_key),
      .hit_value (hit_value)
   );

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= skvr_pkg::COUNT_W'(256);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
